// ===== design/access_list_dedup_table_macros.svh =====
// assertion macros for the access list table
`ifndef ACCESS_LIST_DEDUP_TABLE_MACROS_SVH
`define ACCESS_LIST_DEDUP_TABLE_MACROS_SVH
`define ALDT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ALDT_ASSERT_NORST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== design/aldt_pkg.sv =====
package aldt_pkg;
	localparam int TableEntries = 16;
	localparam int KeysPerEntry = 32;
	localparam int EIdxW = $clog2(TableEntries);
	localparam int KIdxW = $clog2(KeysPerEntry);
	localparam int ECntW = $clog2(TableEntries + 1);
	localparam int KCntW = $clog2(KeysPerEntry + 1);
	localparam int KeyMemDepth = TableEntries * KeysPerEntry;
	localparam int KeyMemAw = $clog2(KeyMemDepth);

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_ADD_KEY = 2'd0;
	localparam cmd_t CMD_ADD_ADDR = 2'd1;
	localparam cmd_t CMD_PRUNE = 2'd2;
	localparam cmd_t CMD_UNUSED = 2'd3;

	typedef logic [2:0] status_t;
	localparam status_t ST_NEW = 3'd0;
	localparam status_t ST_APPENDED = 3'd1;
	localparam status_t ST_PRESENT = 3'd2;
	localparam status_t ST_TABLE_FULL = 3'd3;
	localparam status_t ST_KEYS_FULL = 3'd4;
	localparam status_t ST_PRUNED = 3'd5;
	localparam status_t ST_KEPT = 3'd6;

	localparam logic [1:0] REG_COLD = 2'd0;
	localparam logic [1:0] REG_WARM = 2'd1;
	localparam logic [1:0] REG_KEY = 2'd2;
	localparam logic [1:0] REG_ADDR = 2'd3;

	typedef struct packed {
		logic [15:0] cold;
		logic [15:0] warm;
		logic [15:0] key;
		logic [15:0] addr;
	} cost_cfg_t;
endpackage

// ===== design/access_list_dedup_table.sv =====
// timing: the result of an add or prune command follows the serial address search (a cycle an entry)
// and, for an add key, the key search, while an unused command goes straight to the result
// a prune that removes an entry also copies down each key slot moved (up to 15*32 slots)
// throughput: one transaction at a time, not ready until the result is taken
// reset: asynchronous, clears entry count and restores default costs; table contents undefined
module access_list_dedup_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [423:0] s_tdata, // command, addr_high, addr_mid, addr_low, key_word3..key_word0
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [23:0]  m_tdata, // status, entry_index, key_count, entry_count
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import aldt_pkg::*;
	cost_cfg_t cfg;
	logic [417:0] din;
	logic [17:0] dout;
	// internal order: cmd, addr low..high, key word0..word3
	assign din = {s_tdata[225:162], s_tdata[289:226], s_tdata[353:290], s_tdata[417:354],
	              s_tdata[33:2], s_tdata[97:34], s_tdata[161:98], s_tdata[1:0]};
	assign m_tdata = {6'd0, dout};
	aldt_cfg_regs u_cfg (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg);
	aldt_engine u_eng (.clk, .arst_n, .cfg, .in_valid(s_tvalid), .in_ready(s_tready),
		.in_data(din), .out_ready(m_tready), .out_valid(m_tvalid), .out_data(dout));
endmodule

// ===== design/aldt_cfg_regs.sv =====
module aldt_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output aldt_pkg::cost_cfg_t cfg
);
	import aldt_pkg::*;
	cost_cfg_t cfg_q;
	logic wr;
	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{cold: 16'd2100, warm: 16'd100, key: 16'd1900, addr: 16'd2400};
		end else if (wr && paddr[1:0] == 2'b00) begin
			case (paddr[3:2])
				REG_COLD: cfg_q.cold <= pwdata[15:0];
				REG_WARM: cfg_q.warm <= pwdata[15:0];
				REG_KEY:  cfg_q.key <= pwdata[15:0];
				REG_ADDR: cfg_q.addr <= pwdata[15:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (paddr[3:2])
				REG_COLD: prdata = {16'd0, cfg_q.cold};
				REG_WARM: prdata = {16'd0, cfg_q.warm};
				REG_KEY:  prdata = {16'd0, cfg_q.key};
				REG_ADDR: prdata = {16'd0, cfg_q.addr};
				default:  prdata = '0;
			endcase
		end
	end
	assign cfg = cfg_q;
endmodule

// ===== design/aldt_engine.sv =====
module aldt_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  aldt_pkg::cost_cfg_t cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [417:0]        in_data,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [17:0]         out_data
);
	import aldt_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_ADDR   = 9'b000000010,
		S_KREAD  = 9'b000000100,
		S_KCMP   = 9'b000001000,
		S_DECIDE = 9'b000010000,
		S_MUL    = 9'b000100000,
		S_SHIFT  = 9'b001000000,
		S_SHKW   = 9'b010000000,
		S_OUT    = 9'b100000000
	} state_t;
	state_t state_q;

	logic [1:0]   cmd_q;
	logic [159:0] addr_q;
	logic [255:0] key_q;
	logic [159:0] addr_mem [TableEntries];
	logic [KCntW-1:0] kcnt_mem [TableEntries];
	logic [255:0] key_mem [KeyMemDepth];
	logic [255:0] key_rd_q;
	logic [KeyMemAw-1:0] key_raddr;
	logic key_we;
	logic [KeyMemAw-1:0] key_waddr;
	logic [255:0] key_wdata;

	logic [ECntW-1:0] used_q;
	logic [ECntW-1:0] e_q;
	logic [KCntW-1:0] j_q;
	logic found_q, kfound_q;
	logic [2:0] status_q;
	logic [EIdxW-1:0] idx_q;
	logic [KCntW-1:0] cnt_q;
	logic [15:0] save_q;
	logic [23:0] prod_q;

	logic [EIdxW-1:0] e_idx;
	logic [EIdxW-1:0] e_nxt;
	logic [16:0] spent;
	assign e_idx = e_q[EIdxW-1:0];
	assign e_nxt = EIdxW'(e_q + 1'b1);
	assign spent = {1'b0, cfg.warm} + {1'b0, cfg.key};

	// key memory, one read and one write port
	always_ff @(posedge clk) begin
		if (key_we) key_mem[key_waddr] <= key_wdata;
		key_rd_q <= key_mem[key_raddr];
	end

	always_comb begin
		key_raddr = {e_idx, j_q[KIdxW-1:0]};
		if (state_q == S_SHIFT) key_raddr = {e_nxt, j_q[KIdxW-1:0]};
		key_we = 1'b0;
		// a new entry takes its first key in slot zero
		key_waddr = found_q ? {idx_q, cnt_q[KIdxW-1:0]} : {used_q[EIdxW-1:0], KIdxW'(0)};
		key_wdata = key_q;
		if (state_q == S_DECIDE && cmd_q == CMD_ADD_KEY && !kfound_q &&
		    (found_q ? cnt_q < KCntW'(KeysPerEntry) : used_q < ECntW'(TableEntries))) begin
			key_we = 1'b1;
		end
		if (state_q == S_SHKW) begin
			key_we = 1'b1;
			key_waddr = {e_idx, j_q[KIdxW-1:0]};
			key_wdata = key_rd_q;
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign out_data = {used_q, cnt_q, idx_q, status_q};

	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE && cmd_q != CMD_PRUNE && !found_q &&
		    used_q < ECntW'(TableEntries)) begin
			addr_mem[used_q[EIdxW-1:0]] <= addr_q;
			kcnt_mem[used_q[EIdxW-1:0]] <= (cmd_q == CMD_ADD_KEY) ? KCntW'(1) : '0;
		end else if (state_q == S_DECIDE && found_q && !kfound_q &&
		             cmd_q == CMD_ADD_KEY && cnt_q < KCntW'(KeysPerEntry)) begin
			kcnt_mem[idx_q] <= cnt_q + 1'b1;
		end else if (state_q == S_SHIFT && j_q == '0) begin
			addr_mem[e_idx] <= addr_mem[e_nxt];
			kcnt_mem[e_idx] <= kcnt_mem[e_nxt];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q <= in_data[1:0];
			addr_q <= in_data[161:2];
			key_q <= in_data[417:162];
		end
		if (state_q == S_MUL) prod_q <= save_q * 24'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			e_q <= '0;
			j_q <= '0;
			found_q <= 1'b0;
			kfound_q <= 1'b0;
			status_q <= ST_KEPT;
			idx_q <= '0;
			cnt_q <= '0;
			save_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					e_q <= '0;
					j_q <= '0;
					found_q <= 1'b0;
					kfound_q <= 1'b0;
					idx_q <= '0;
					cnt_q <= '0;
					status_q <= ST_KEPT;
					state_q <= (in_data[1:0] == CMD_UNUSED) ? S_OUT : S_ADDR;
				end
				// address search, one entry a cycle
				S_ADDR: begin
					if (e_q >= used_q) begin
						state_q <= S_DECIDE;
					end else if (addr_mem[e_idx] == addr_q) begin
						found_q <= 1'b1;
						idx_q <= e_idx;
						cnt_q <= kcnt_mem[e_idx];
						j_q <= '0;
						state_q <= (cmd_q == CMD_ADD_KEY) ? S_KREAD : S_DECIDE;
					end else begin
						e_q <= e_q + 1'b1;
					end
				end
				S_KREAD: state_q <= (j_q >= cnt_q) ? S_DECIDE : S_KCMP;
				S_KCMP: begin
					if (key_rd_q == key_q) begin
						kfound_q <= 1'b1;
						state_q <= S_DECIDE;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_KREAD;
					end
				end
				S_DECIDE: begin
					state_q <= S_OUT;
					if (cmd_q == CMD_PRUNE) begin
						if (found_q) begin
							save_q <= ({1'b0, cfg.cold} > spent) ?
								16'({1'b0, cfg.cold} - spent) : '0;
							state_q <= S_MUL;
						end else begin
							idx_q <= '0;
							cnt_q <= '0;
							status_q <= ST_KEPT;
						end
					end else if (found_q) begin
						if (cmd_q == CMD_ADD_ADDR || kfound_q) status_q <= ST_PRESENT;
						else if (cnt_q >= KCntW'(KeysPerEntry)) status_q <= ST_KEYS_FULL;
						else begin
							cnt_q <= cnt_q + 1'b1;
							status_q <= ST_APPENDED;
						end
					end else if (used_q >= ECntW'(TableEntries)) begin
						status_q <= ST_TABLE_FULL;
					end else begin
						idx_q <= used_q[EIdxW-1:0];
						cnt_q <= (cmd_q == CMD_ADD_KEY) ? KCntW'(1) : '0;
						used_q <= used_q + 1'b1;
						status_q <= ST_NEW;
					end
				end
				S_MUL: state_q <= S_SHKW;
				S_SHKW: begin
					// first visit checks the product, later visits copy keys down
					if (status_q == ST_KEPT && !kfound_q) begin
						kfound_q <= 1'b1;
						if (prod_q <= 24'(cfg.addr)) begin
							status_q <= ST_PRUNED;
							e_q <= {1'b0, idx_q};
							j_q <= '0;
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_OUT;
						end
					end else if (j_q == KCntW'(KeysPerEntry - 1)) begin
						j_q <= '0;
						e_q <= e_q + 1'b1;
						state_q <= S_SHIFT;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (e_q + 1'b1 >= used_q) begin
						used_q <= used_q - 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_SHKW;
					end
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/access_list_dedup_table_checker.sv =====
`include "access_list_dedup_table_macros.svh"
module access_list_dedup_table_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	`ALDT_ASSERT(a_one_side, clk, arst_n, !(s_tready && m_tvalid), "ready while result pending")
	`ALDT_ASSERT(a_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped")
	`ALDT_ASSERT(a_status, clk, arst_n, m_tvalid |-> m_tdata[2:0] != 3'd7, "bad status")
	`ALDT_ASSERT_NORST(a_rst, clk, !arst_n |=> !m_tvalid, "valid in reset")
endmodule
bind access_list_dedup_table access_list_dedup_table_checker u_chk (.*);
